// ----- design/ufcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_pkg: shared definitions for the flow-controlled serial buffers
// Event codes, configuration register indexes, status bit masks and the
// command bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package ufcb_pkg;

	localparam int DEF_RX_DEPTH = 1024;
	localparam int DEF_TX_DEPTH = 1024;

	// Event codes carried by the action field.
	localparam logic [3:0] ACT_RX_BYTE      = 4'd0;
	localparam logic [3:0] ACT_HOST_READ    = 4'd1;
	localparam logic [3:0] ACT_HOST_WRITE   = 4'd2;
	localparam logic [3:0] ACT_TX_TICK      = 4'd3;
	localparam logic [3:0] ACT_MODEM_STATUS = 4'd4;
	localparam logic [3:0] ACT_LINE_STATUS  = 4'd5;
	localparam logic [3:0] ACT_RX_CANCEL    = 4'd6;
	localparam logic [3:0] ACT_TX_CANCEL    = 4'd7;
	localparam logic [3:0] ACT_COUNTER_READ = 4'd8;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_XOFF_CHAR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOFT_FLOW   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_LINE  = 2'd2;

	localparam logic [7:0] XOFF_CHAR_RESET = 8'd19;

	// Modem status bits.
	localparam logic [7:0] MS_CTS       = 8'h10;
	localparam logic [7:0] MS_DCD       = 8'h80;
	localparam logic [7:0] MS_DCD_DELTA = 8'h08;

	// Line status bits.
	localparam logic [7:0] LSR_OVERRUN = 8'h02;
	localparam logic [7:0] LSR_PARITY  = 8'h04;
	localparam logic [7:0] LSR_FRAMING = 8'h08;
	localparam logic [7:0] LSR_BREAK   = 8'h10;

	// Error counter indexes.
	localparam logic [1:0] CNT_FRAMING = 2'd0;
	localparam logic [1:0] CNT_OVERRUN = 2'd1;
	localparam logic [1:0] CNT_PARITY  = 2'd2;
	localparam logic [1:0] CNT_BREAK   = 2'd3;

	typedef struct packed {
		logic capture;  // take the input transaction and launch ring reads
		logic commit;   // apply the event and load the result register
	} ufcb_cmd_t;

endpackage
`default_nettype wire

// ----- design/ufcb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ufcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/ufcb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_ctrl: transaction sequencer
// Captures one input transaction and launches the ring reads, then, in the
// EXEC state, commits the event once the result register is free.
// ----------------------------------------------------------------------------
module ufcb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ufcb_pkg::ufcb_cmd_t     cmd
);
	import ufcb_pkg::*;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	// The result register is free when empty or being drained this cycle.
	assign commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit  = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/ufcb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_datapath: ring buffers, flow control state and result register
// Holds both rings in RAM, their pointers and fill counts, the RTS, CTS,
// XON/XOFF and hangup flags, the line error counters and configuration.
// ----------------------------------------------------------------------------
module ufcb_datapath #(
	parameter int RX_DEPTH = ufcb_pkg::DEF_RX_DEPTH,
	parameter int TX_DEPTH = ufcb_pkg::DEF_TX_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ufcb_pkg::ufcb_cmd_t                 cmd,
	input  wire logic                                cfg_write,
	input  wire logic [ufcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ufcb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [3:0]                          action,
	input  wire logic [7:0]                          data,
	input  wire logic [7:0]                          status,
	input  wire logic                                tx_idle,
	output logic                                     tx_valid,
	output logic      [7:0]                          tx_byte,
	output logic                                     read_valid,
	output logic      [7:0]                          read_byte,
	output logic                                     write_accepted,
	output logic                                     rx_dropped,
	output logic                                     rts_level,
	output logic                                     notify,
	output logic                                     hangup,
	output logic      [$clog2(RX_DEPTH+1)-1:0]       rx_level,
	output logic      [$clog2(TX_DEPTH+1)-1:0]       tx_level,
	output logic      [31:0]                         counter_value
);
	import ufcb_pkg::*;

	localparam int RXA = $clog2(RX_DEPTH);
	localparam int TXA = $clog2(TX_DEPTH);
	localparam int RXC = $clog2(RX_DEPTH + 1);
	localparam int TXC = $clog2(TX_DEPTH + 1);

	localparam logic [RXC-1:0] RX_FULL    = RXC'(RX_DEPTH);
	localparam logic [RXC-1:0] RX_RTS_OFF = RXC'(3 * RX_DEPTH / 4);
	localparam logic [RXC-1:0] RX_RTS_ON  = RXC'(RX_DEPTH / 4);
	localparam logic [RXA-1:0] RX_LAST    = RXA'(RX_DEPTH - 1);
	localparam logic [TXC-1:0] TX_FULL    = TXC'(TX_DEPTH);
	localparam logic [TXC-1:0] TX_LOW     = TXC'(TX_DEPTH / 4);
	localparam logic [TXA-1:0] TX_LAST    = TXA'(TX_DEPTH - 1);

	// Captured transaction.
	logic [3:0] action_q;
	logic [7:0] data_q;
	logic [7:0] status_q;
	logic       tx_idle_q;

	// Configuration.
	logic [7:0] xoff_char_q;
	logic       soft_flow_q;
	logic       local_line_q;

	// Ring and flow control state.
	logic [RXA-1:0] rx_head_q, rx_tail_q, rx_head_n, rx_tail_n;
	logic [RXC-1:0] rx_fill_q, rx_fill_n;
	logic [TXA-1:0] tx_head_q, tx_tail_q, tx_head_n, tx_tail_n;
	logic [TXC-1:0] tx_fill_q, tx_fill_n;
	logic           rts_q, rts_n;
	logic           sw_ready_q, sw_ready_n;
	logic           cts_q, cts_n;
	logic           hang_q, hang_n;
	logic [31:0]    err_cnt_q [4];
	logic [31:0]    err_cnt_n [4];

	// RAM ports.
	logic       rx_we, tx_we;
	logic [7:0] rx_rd_data, tx_rd_data;

	// Result of the event being committed.
	logic        o_tx_valid, o_read_valid, o_write_accepted, o_rx_dropped;
	logic        o_notify, o_hangup;
	logic [7:0]  o_tx_byte, o_read_byte;
	logic [31:0] o_counter;
	logic        send_req;

	// Result register.
	logic           tx_valid_q, read_valid_q, write_accepted_q, rx_dropped_q;
	logic           rts_level_q, notify_q, hangup_q;
	logic [7:0]     tx_byte_q, read_byte_q;
	logic [RXC-1:0] rx_level_q;
	logic [TXC-1:0] tx_level_q;
	logic [31:0]    counter_q;

	ufcb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_q),
		.wdata (data_q),
		.re    (cmd.capture),
		.raddr (rx_tail_q),
		.rdata (rx_rd_data)
	);

	ufcb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_q),
		.wdata (data_q),
		.re    (cmd.capture),
		.raddr (tx_tail_q),
		.rdata (tx_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			data_q    <= data;
			status_q  <= status;
			tx_idle_q <= tx_idle;
		end
	end

	always_comb begin
		rx_head_n        = rx_head_q;
		rx_tail_n        = rx_tail_q;
		rx_fill_n        = rx_fill_q;
		tx_head_n        = tx_head_q;
		tx_tail_n        = tx_tail_q;
		tx_fill_n        = tx_fill_q;
		rts_n            = rts_q;
		sw_ready_n       = sw_ready_q;
		cts_n            = cts_q;
		hang_n           = hang_q;
		err_cnt_n        = err_cnt_q;
		rx_we            = 1'b0;
		tx_we            = 1'b0;
		send_req         = 1'b0;
		o_tx_valid       = 1'b0;
		o_tx_byte        = 8'd0;
		o_read_valid     = 1'b0;
		o_read_byte      = 8'd0;
		o_write_accepted = 1'b0;
		o_rx_dropped     = 1'b0;
		o_notify         = 1'b0;
		o_hangup         = 1'b0;
		o_counter        = 32'd0;

		case (action_q)
			ACT_RX_BYTE: begin
				if (soft_flow_q) begin
					if (data_q == xoff_char_q) begin
						sw_ready_n = 1'b0;
					end else if (!sw_ready_q) begin
						sw_ready_n = 1'b1;
						send_req   = 1'b1;
					end
				end
				if (rx_fill_q == RX_FULL) begin
					o_rx_dropped = 1'b1;
				end else begin
					rx_fill_n = rx_fill_q + 1'b1;
					if (rx_fill_n == RX_RTS_OFF) begin
						rts_n = 1'b0;
					end
					rx_we     = 1'b1;
					rx_head_n = (rx_head_q == RX_LAST) ? '0 : rx_head_q + 1'b1;
					if (rx_fill_q == '0) begin
						o_notify = 1'b1;
					end
				end
			end
			ACT_HOST_READ: begin
				if (!local_line_q && hang_q) begin
					hang_n   = 1'b0;
					o_hangup = 1'b1;
				end else if (rx_fill_q != '0) begin
					o_read_valid = 1'b1;
					o_read_byte  = rx_rd_data;
					rx_tail_n    = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + 1'b1;
					rx_fill_n    = rx_fill_q - 1'b1;
					if (!rts_q && rx_fill_n < RX_RTS_ON) begin
						rts_n = 1'b1;
					end
				end
			end
			ACT_HOST_WRITE: begin
				if (tx_fill_q != TX_FULL) begin
					tx_we            = 1'b1;
					tx_head_n        = (tx_head_q == TX_LAST) ? '0 : tx_head_q + 1'b1;
					tx_fill_n        = tx_fill_q + 1'b1;
					o_write_accepted = 1'b1;
					send_req         = 1'b1;
				end
			end
			ACT_TX_TICK: begin
				send_req = 1'b1;
			end
			ACT_MODEM_STATUS: begin
				if ((status_q & (MS_DCD | MS_DCD_DELTA)) == MS_DCD_DELTA) begin
					hang_n   = 1'b1;
					o_notify = 1'b1;
				end
				if (((status_q & MS_CTS) == 8'd0) && !local_line_q) begin
					cts_n = 1'b0;
				end else if (!cts_q) begin
					cts_n    = 1'b1;
					send_req = 1'b1;
				end
			end
			ACT_LINE_STATUS: begin
				if ((status_q & LSR_FRAMING) != 8'd0) begin
					err_cnt_n[CNT_FRAMING] = err_cnt_q[CNT_FRAMING] + 32'd1;
				end
				if ((status_q & LSR_OVERRUN) != 8'd0) begin
					err_cnt_n[CNT_OVERRUN] = err_cnt_q[CNT_OVERRUN] + 32'd1;
				end
				if ((status_q & LSR_PARITY) != 8'd0) begin
					err_cnt_n[CNT_PARITY] = err_cnt_q[CNT_PARITY] + 32'd1;
				end
				if ((status_q & LSR_BREAK) != 8'd0) begin
					err_cnt_n[CNT_BREAK] = err_cnt_q[CNT_BREAK] + 32'd1;
				end
			end
			ACT_RX_CANCEL: begin
				rx_fill_n = '0;
				rx_tail_n = rx_head_q;
				rts_n     = 1'b1;
			end
			ACT_TX_CANCEL: begin
				tx_fill_n = '0;
				tx_tail_n = tx_head_q;
			end
			ACT_COUNTER_READ: begin
				o_counter = err_cnt_q[data_q[1:0]];
			end
			default: begin
			end
		endcase

		// At most one byte leaves per transaction. An empty ring before a host
		// write means the byte at the tail is the one being written now.
		if (send_req && tx_idle_q && (cts_n || local_line_q) && sw_ready_n
				&& (tx_fill_n != '0)) begin
			o_tx_valid = 1'b1;
			o_tx_byte  = (tx_fill_q == '0) ? data_q : tx_rd_data;
			tx_tail_n  = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + 1'b1;
			tx_fill_n  = tx_fill_n - 1'b1;
			if (tx_fill_n == '0 || tx_fill_n == TX_LOW) begin
				o_notify = 1'b1;
			end
		end

		if (!cmd.commit) begin
			rx_we = 1'b0;
			tx_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			rx_fill_q    <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			tx_fill_q    <= '0;
			rts_q        <= 1'b1;
			sw_ready_q   <= 1'b1;
			cts_q        <= 1'b0;
			hang_q       <= 1'b0;
			err_cnt_q    <= '{default: 32'd0};
			xoff_char_q  <= XOFF_CHAR_RESET;
			soft_flow_q  <= 1'b0;
			local_line_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_XOFF_CHAR:  xoff_char_q  <= cfg_data;
					CFG_SOFT_FLOW:  soft_flow_q  <= cfg_data[0];
					CFG_LOCAL_LINE: local_line_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				rx_head_q  <= rx_head_n;
				rx_tail_q  <= rx_tail_n;
				rx_fill_q  <= rx_fill_n;
				tx_head_q  <= tx_head_n;
				tx_tail_q  <= tx_tail_n;
				tx_fill_q  <= tx_fill_n;
				rts_q      <= rts_n;
				sw_ready_q <= sw_ready_n;
				cts_q      <= cts_n;
				hang_q     <= hang_n;
				err_cnt_q  <= err_cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			tx_valid_q       <= o_tx_valid;
			tx_byte_q        <= o_tx_byte;
			read_valid_q     <= o_read_valid;
			read_byte_q      <= o_read_byte;
			write_accepted_q <= o_write_accepted;
			rx_dropped_q     <= o_rx_dropped;
			rts_level_q      <= rts_n;
			notify_q         <= o_notify;
			hangup_q         <= o_hangup;
			rx_level_q       <= rx_fill_n;
			tx_level_q       <= tx_fill_n;
			counter_q        <= o_counter;
		end
	end

	assign tx_valid       = tx_valid_q;
	assign tx_byte        = tx_byte_q;
	assign read_valid     = read_valid_q;
	assign read_byte      = read_byte_q;
	assign write_accepted = write_accepted_q;
	assign rx_dropped     = rx_dropped_q;
	assign rts_level      = rts_level_q;
	assign notify         = notify_q;
	assign hangup         = hangup_q;
	assign rx_level       = rx_level_q;
	assign tx_level       = tx_level_q;
	assign counter_value  = counter_q;

endmodule
`default_nettype wire

// ----- design/uart_flow_controlled_buffers.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_flow_controlled_buffers: serial receive/transmit rings with flow control
// Top level joining the transaction sequencer and the buffer datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one serial event (received byte, host read or
// write, transmitter tick, modem or line status, cancel, counter read) and
// yields exactly one result transaction. An event is handled in a capture
// step, which takes it and reads both ring RAMs at their tails, and an apply
// step, which applies it, writes the ring and loads the result register; the
// registered read of the ring RAMs is why the steps are split. A new event is
// taken while the previous result still waits, and the apply step holds until
// the result register is free. The rings need no clearing after reset: entries
// are only read below the fill level. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module uart_flow_controlled_buffers #(
	parameter int RX_DEPTH = ufcb_pkg::DEF_RX_DEPTH,
	parameter int TX_DEPTH = ufcb_pkg::DEF_TX_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [ufcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ufcb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [3:0]                          action,
	input  wire logic [7:0]                          data,
	input  wire logic [7:0]                          status,
	input  wire logic                                tx_idle,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     tx_valid,
	output logic      [7:0]                          tx_byte,
	output logic                                     read_valid,
	output logic      [7:0]                          read_byte,
	output logic                                     write_accepted,
	output logic                                     rx_dropped,
	output logic                                     rts_level,
	output logic                                     notify,
	output logic                                     hangup,
	output logic      [$clog2(RX_DEPTH+1)-1:0]       rx_level,
	output logic      [$clog2(TX_DEPTH+1)-1:0]       tx_level,
	output logic      [31:0]                         counter_value
);
	import ufcb_pkg::*;

	ufcb_cmd_t cmd;

	ufcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ufcb_datapath #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.data           (data),
		.status         (status),
		.tx_idle        (tx_idle),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.read_valid     (read_valid),
		.read_byte      (read_byte),
		.write_accepted (write_accepted),
		.rx_dropped     (rx_dropped),
		.rts_level      (rts_level),
		.notify         (notify),
		.hangup         (hangup),
		.rx_level       (rx_level),
		.tx_level       (tx_level),
		.counter_value  (counter_value)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for uart_flow_controlled_buffers
// Drives serial events through the valid/ready input channel and checks every
// result transaction against a cycle-free model of both rings, RTS/CTS and
// XON/XOFF flow control, hangup tracking and the line error counters.
// ----------------------------------------------------------------------------
module testbench;
	import ufcb_pkg::*;

	localparam int RX_DEPTH = DEF_RX_DEPTH;
	localparam int TX_DEPTH = DEF_TX_DEPTH;
	localparam int RX_LW = $clog2(RX_DEPTH + 1);
	localparam int TX_LW = $clog2(TX_DEPTH + 1);

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] data;
		logic [7:0] status;
		logic       tx_idle;
	} serial_event_t;

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             read_valid;
		logic [7:0]       read_byte;
		logic             write_accepted;
		logic             rx_dropped;
		logic             rts_level;
		logic             notify;
		logic             hangup;
		logic [RX_LW-1:0] rx_level;
		logic [TX_LW-1:0] tx_level;
		logic [31:0]      counter_value;
	} serial_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] action = '0;
	logic [7:0] data = '0;
	logic [7:0] status = '0;
	logic tx_idle = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic read_valid;
	logic [7:0] read_byte;
	logic write_accepted;
	logic rx_dropped;
	logic rts_level;
	logic notify;
	logic hangup;
	logic [RX_LW-1:0] rx_level;
	logic [TX_LW-1:0] tx_level;
	logic [31:0] counter_value;

	serial_event_t pending_events[$];
	serial_result_t expected_results[$];
	serial_event_t next_event;
	serial_result_t pred;
	serial_result_t seen;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Model of the buffers and flow control state.
	logic [7:0] rxbuf_mem[RX_DEPTH];
	int rxbuf_wr, rxbuf_rd, rxbuf_count;
	logic [7:0] txbuf_mem[TX_DEPTH];
	int txbuf_wr, txbuf_rd, txbuf_count;
	logic rts_up, xon, cts_seen, carrier_lost;
	logic [31:0] err_count[4];
	logic [7:0] xoff_byte;
	logic soft_flow_on, local_mode;

	uart_flow_controlled_buffers dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.data(data),
		.status(status),
		.tx_idle(tx_idle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.write_accepted(write_accepted),
		.rx_dropped(rx_dropped),
		.rts_level(rts_level),
		.notify(notify),
		.hangup(hangup),
		.rx_level(rx_level),
		.tx_level(tx_level),
		.counter_value(counter_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("uart_flow_controlled_buffers test failed");
		$finish;
	end

	function automatic void reset_model();
		rxbuf_wr = 0;
		rxbuf_rd = 0;
		rxbuf_count = 0;
		txbuf_wr = 0;
		txbuf_rd = 0;
		txbuf_count = 0;
		rts_up = 1'b1;
		xon = 1'b1;
		cts_seen = 1'b0;
		carrier_lost = 1'b0;
		for (int k = 0; k < 4; k++)
			err_count[k] = '0;
		xoff_byte = XOFF_CHAR_RESET;
		soft_flow_on = 1'b0;
		local_mode = 1'b0;
	endfunction

	// At most one byte leaves per event, and only with every gate open.
	function automatic void attempt_transmit(logic idle);
		if (idle && (cts_seen || local_mode) && xon && txbuf_count != 0) begin
			pred.tx_valid = 1'b1;
			pred.tx_byte = txbuf_mem[txbuf_rd];
			txbuf_rd = (txbuf_rd + 1) % TX_DEPTH;
			txbuf_count--;
			if (txbuf_count == 0 || txbuf_count == TX_DEPTH / 4)
				pred.notify = 1'b1;
		end
	endfunction

	function automatic void predict_event(serial_event_t ev);
		logic cts_in;
		pred = '0;
		case (ev.action)
			ACT_RX_BYTE: begin
				if (soft_flow_on) begin
					if (ev.data == xoff_byte) begin
						xon = 1'b0;
					end else if (!xon) begin
						xon = 1'b1;
						attempt_transmit(ev.tx_idle);
					end
				end
				if (rxbuf_count >= RX_DEPTH) begin
					pred.rx_dropped = 1'b1;
				end else begin
					rxbuf_count++;
					if (rxbuf_count == 3 * RX_DEPTH / 4)
						rts_up = 1'b0;
					rxbuf_mem[rxbuf_wr] = ev.data;
					rxbuf_wr = (rxbuf_wr + 1) % RX_DEPTH;
					if (rxbuf_count == 1)
						pred.notify = 1'b1;
				end
			end
			ACT_HOST_READ: begin
				if (!local_mode && carrier_lost) begin
					carrier_lost = 1'b0;
					pred.hangup = 1'b1;
				end else if (rxbuf_count != 0) begin
					pred.read_valid = 1'b1;
					pred.read_byte = rxbuf_mem[rxbuf_rd];
					rxbuf_rd = (rxbuf_rd + 1) % RX_DEPTH;
					rxbuf_count--;
					if (!rts_up && rxbuf_count < RX_DEPTH / 4)
						rts_up = 1'b1;
				end
			end
			ACT_HOST_WRITE: begin
				if (txbuf_count < TX_DEPTH) begin
					txbuf_mem[txbuf_wr] = ev.data;
					txbuf_wr = (txbuf_wr + 1) % TX_DEPTH;
					txbuf_count++;
					pred.write_accepted = 1'b1;
					attempt_transmit(ev.tx_idle);
				end
			end
			ACT_TX_TICK: attempt_transmit(ev.tx_idle);
			ACT_MODEM_STATUS: begin
				cts_in = ((ev.status & MS_CTS) != 0) || local_mode;
				// Hangup is a change of carrier that leaves DCD low.
				if ((ev.status & (MS_DCD | MS_DCD_DELTA)) == MS_DCD_DELTA) begin
					carrier_lost = 1'b1;
					pred.notify = 1'b1;
				end
				if (!cts_in) begin
					cts_seen = 1'b0;
				end else if (!cts_seen) begin
					cts_seen = 1'b1;
					attempt_transmit(ev.tx_idle);
				end
			end
			ACT_LINE_STATUS: begin
				if ((ev.status & LSR_FRAMING) != 0) err_count[CNT_FRAMING]++;
				if ((ev.status & LSR_OVERRUN) != 0) err_count[CNT_OVERRUN]++;
				if ((ev.status & LSR_PARITY) != 0) err_count[CNT_PARITY]++;
				if ((ev.status & LSR_BREAK) != 0) err_count[CNT_BREAK]++;
			end
			ACT_RX_CANCEL: begin
				rxbuf_count = 0;
				rxbuf_rd = rxbuf_wr;
				rts_up = 1'b1;
			end
			ACT_TX_CANCEL: begin
				txbuf_count = 0;
				txbuf_rd = txbuf_wr;
			end
			ACT_COUNTER_READ: pred.counter_value = err_count[ev.data[1:0]];
			default: ;
		endcase
		pred.rts_level = rts_up;
		pred.rx_level = RX_LW'(rxbuf_count);
		pred.tx_level = TX_LW'(txbuf_count);
		expected_results.push_back(pred);
	endfunction

	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			// Keep the log readable when the design is badly broken.
			if (mismatch_count <= 100)
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endfunction

	// Input driver: valid is held with a stable payload until the transaction
	// is taken; a new event is offered only when the channel is free.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			predict_event('{action, data, status, tx_idle});
		if (!in_valid || in_ready) begin
			if (arst_n && pending_events.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				next_event = pending_events.pop_front();
				in_valid <= 1'b1;
				action <= next_event.action;
				data <= next_event.data;
				status <= next_event.status;
				tx_idle <= next_event.tx_idle;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transaction with no expectation pending", $time);
			end else begin
				seen = expected_results.pop_front();
				compare_field("tx_valid", 32'(seen.tx_valid), 32'(tx_valid));
				compare_field("tx_byte", 32'(seen.tx_byte), 32'(tx_byte));
				compare_field("read_valid", 32'(seen.read_valid), 32'(read_valid));
				compare_field("read_byte", 32'(seen.read_byte), 32'(read_byte));
				compare_field("write_accepted", 32'(seen.write_accepted),
					32'(write_accepted));
				compare_field("rx_dropped", 32'(seen.rx_dropped), 32'(rx_dropped));
				compare_field("rts_level", 32'(seen.rts_level), 32'(rts_level));
				compare_field("notify", 32'(seen.notify), 32'(notify));
				compare_field("hangup", 32'(seen.hangup), 32'(hangup));
				compare_field("rx_level", 32'(seen.rx_level), 32'(rx_level));
				compare_field("tx_level", 32'(seen.tx_level), 32'(tx_level));
				compare_field("counter_value", seen.counter_value, counter_value);
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic serial_event_t make_event(logic [3:0] a, logic [7:0] d,
			logic [7:0] s, logic i);
		serial_event_t ev;
		ev.action = a;
		ev.data = d;
		ev.status = s;
		ev.tx_idle = i;
		return ev;
	endfunction

	function automatic serial_event_t mixed_event();
		int pick;
		logic [7:0] d;
		logic [7:0] s;
		logic i;
		pick = $urandom_range(99);
		d = 8'($urandom_range(255));
		s = 8'($urandom_range(255));
		i = $urandom_range(99) < 75;
		if (pick < 24) begin
			if ($urandom_range(4) == 0)
				d = xoff_byte;
			return make_event(ACT_RX_BYTE, d, s, i);
		end
		if (pick < 44) return make_event(ACT_HOST_READ, d, s, i);
		if (pick < 64) return make_event(ACT_HOST_WRITE, d, s, i);
		if (pick < 74) return make_event(ACT_TX_TICK, d, s, i);
		if (pick < 82) return make_event(ACT_MODEM_STATUS, d, s, i);
		if (pick < 88) return make_event(ACT_LINE_STATUS, d, s, i);
		if (pick < 90) return make_event(ACT_RX_CANCEL, d, s, i);
		if (pick < 92) return make_event(ACT_TX_CANCEL, d, s, i);
		return make_event(ACT_COUNTER_READ, d, s, i);
	endfunction

	// Events that leave both ring levels alone while CTS is low.
	function automatic serial_event_t side_event();
		logic [7:0] d;
		logic [7:0] s;
		logic i;
		d = 8'($urandom_range(255));
		s = 8'($urandom_range(255));
		i = 1'($urandom_range(1));
		case ($urandom_range(2))
			0: return make_event(ACT_TX_TICK, d, s, i);
			1: return make_event(ACT_LINE_STATUS, d, s, i);
			default: return make_event(ACT_COUNTER_READ, d, s, i);
		endcase
	endfunction

	task automatic queue_mixed(int count);
		for (int k = 0; k < count; k++)
			pending_events.push_back(mixed_event());
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_XOFF_CHAR: xoff_byte = value;
			CFG_SOFT_FLOW: soft_flow_on = value[0];
			CFG_LOCAL_LINE: local_mode = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	initial begin
		int n;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed events at the reset settings.
		set_idling(0, 0);
		pending_events.push_back(make_event(ACT_HOST_READ, 8'h00, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_COUNTER_READ, 8'hFF, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_LINE_STATUS, 8'h00, 8'hFF, 1'b0));
		pending_events.push_back(make_event(ACT_LINE_STATUS, 8'hFF, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_COUNTER_READ, 8'h00, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_COUNTER_READ, 8'h01, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_COUNTER_READ, 8'h02, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_COUNTER_READ, 8'hFC, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, MS_DCD_DELTA, 1'b1));
		pending_events.push_back(make_event(ACT_HOST_READ, 8'h00, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_RX_BYTE, 8'hFF, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_RX_BYTE, 8'h00, 8'hFF, 1'b1));
		pending_events.push_back(make_event(ACT_HOST_WRITE, 8'hAA, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, MS_CTS, 1'b1));
		pending_events.push_back(make_event(ACT_HOST_WRITE, 8'h55, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_TX_TICK, 8'h00, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, 8'h98, 1'b1));
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_HOST_READ, 8'h00, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_RX_CANCEL, 8'h00, 8'h00, 1'b0));
		pending_events.push_back(make_event(ACT_HOST_WRITE, 8'h01, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_TX_CANCEL, 8'h00, 8'h00, 1'b1));
		wait_drained();

		// Software flow control: XOFF holds a queued byte, another byte frees it.
		write_register(CFG_SOFT_FLOW, 8'd1);
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, MS_CTS, 1'b0));
		pending_events.push_back(make_event(ACT_RX_BYTE, XOFF_CHAR_RESET, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_HOST_WRITE, 8'h77, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_RX_BYTE, 8'h11, 8'h00, 1'b1));
		queue_mixed(40);
		// The sender stops here until every result has come back.
		wait_drained();
		queue_mixed(30);
		wait_drained();

		write_register(CFG_XOFF_CHAR, 8'h00);
		write_register(CFG_LOCAL_LINE, 8'd1);
		set_idling(73, 0);
		queue_mixed(50);
		wait_drained();

		// Fill the receive ring past full, read a few bytes back, then cancel.
		write_register(CFG_XOFF_CHAR, 8'hFF);
		write_register(CFG_SOFT_FLOW, 8'd0);
		write_register(CFG_LOCAL_LINE, 8'd0);
		set_idling(0, 73);
		for (n = 0; n < RX_DEPTH + 2; n++) begin
			if ($urandom_range(39) == 0)
				pending_events.push_back(side_event());
			pending_events.push_back(make_event(ACT_RX_BYTE, 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'($urandom_range(1))));
		end
		for (n = 0; n < 10; n++)
			pending_events.push_back(make_event(ACT_HOST_READ, 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'($urandom_range(1))));
		pending_events.push_back(make_event(ACT_RX_CANCEL, 8'h00, 8'h00, 1'b0));
		wait_drained();

		// Load the transmit ring with CTS low, then let CTS rise and send it
		// down through the low-water mark.
		write_register(CFG_XOFF_CHAR, 8'($urandom_range(254, 1)));
		write_register(CFG_SOFT_FLOW, 8'd1);
		set_idling(36, 36);
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, 8'h00, 1'b1));
		pending_events.push_back(make_event(ACT_RX_BYTE, xoff_byte ^ 8'h01, 8'h00, 1'b0));
		for (n = 0; n < TX_DEPTH / 4 + 2; n++) begin
			if ($urandom_range(39) == 0)
				pending_events.push_back(side_event());
			pending_events.push_back(make_event(ACT_HOST_WRITE, 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'($urandom_range(1))));
		end
		pending_events.push_back(make_event(ACT_MODEM_STATUS, 8'h00, MS_CTS, 1'b1));
		for (n = 0; n < 12; n++)
			pending_events.push_back(make_event(ACT_TX_TICK, 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'b1));
		pending_events.push_back(make_event(ACT_TX_CANCEL, 8'h00, 8'h00, 1'b1));
		queue_mixed(30);
		wait_drained();

		write_register(CFG_XOFF_CHAR, XOFF_CHAR_RESET);
		write_register(CFG_SOFT_FLOW, 8'd0);
		set_idling(0, 0);
		queue_mixed(30);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("uart_flow_controlled_buffers test passed");
		else
			$display("uart_flow_controlled_buffers test failed");
		$finish;
	end

endmodule
